/* rtl/hdcm_pkg.sv */
// shared types, register codes and reset values for the hsv dual colour mask
package hdcm_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned BOUNDS_W = 48;
    localparam int unsigned CFG_IDX_W = 2;

    // reset windows: yellow h 6..30 s 51..235 v 75..255
    localparam logic [BOUNDS_W-1:0] YELLOW_RESET     = 48'd280701533625862;
    // blue h 106..155 s 59..255 v 29..255
    localparam logic [BOUNDS_W-1:0] BLUE_RESET       = 48'd280504301230954;
    // reflection h 121..179 s 0..98 v 0..255
    localparam logic [BOUNDS_W-1:0] REFLECTION_RESET = 48'd280377109295993;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YELLOW     = 2'd0,
        CFG_BLUE       = 2'd1,
        CFG_REFLECTION = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] h;
        logic [CHAN_W-1:0] s;
        logic [CHAN_W-1:0] v;
    } hsv_t;

endpackage

/* rtl/hdcm_hsv_conv.sv */
// four-stage pipelined bgr to hsv converter with reciprocal-table division
module hdcm_hsv_conv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hdcm_pkg::CHAN_W-1:0]    pixel_blue,
    input  logic [hdcm_pkg::CHAN_W-1:0]    pixel_green,
    input  logic [hdcm_pkg::CHAN_W-1:0]    pixel_red,
    output logic                           out_valid,
    input  logic                           out_ready,
    output hdcm_pkg::hsv_t                 out_hsv
);

    localparam int unsigned RECIP_SHIFT = 18;
    localparam int unsigned RECIP_W     = 18;
    localparam int unsigned RECIP_ONE   = 2 ** (RECIP_SHIFT - 1);
    localparam int unsigned NUM_W       = 17;
    localparam int unsigned WIDE_W      = 18;
    localparam int unsigned PROD_W      = NUM_W + RECIP_W;
    localparam int unsigned ROM_DEPTH   = 256;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // floor(2^17 / x): one-sided reciprocal, quotient estimate is low by at most one
    logic [RECIP_W-1:0] recip_rom [ROM_DEPTH];
    for (genvar Idx = 0; Idx < ROM_DEPTH; Idx++) begin : g_recip
        localparam int unsigned RecipVal = RECIP_ONE / ((Idx == 0) ? 1 : Idx);
        assign recip_rom[Idx] = RECIP_W'(RecipVal);
    end

    // stage ready chain
    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    assign rdy_d    = !vld_d_reg || out_ready;
    assign rdy_c    = !vld_c_reg || rdy_d;
    assign rdy_b    = !vld_b_reg || rdy_c;
    assign rdy_a    = !vld_a_reg || rdy_b;
    assign in_ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) vld_a_reg <= in_valid;
            if (rdy_b) vld_b_reg <= vld_a_reg;
            if (rdy_c) vld_c_reg <= vld_b_reg;
            if (rdy_d) vld_d_reg <= vld_c_reg;
        end
    end

    // stage a: max, min, sector
    logic [7:0] a_blue_reg, a_green_reg, a_red_reg, a_max_reg, a_diff_reg;
    logic [7:0] a_blue_next, a_green_next, a_red_next, a_max_next, a_diff_next;
    sector_t    a_sec_reg, a_sec_next;
    logic [7:0] a_min;

    always_comb
    begin
        a_blue_next  = pixel_blue;
        a_green_next = pixel_green;
        a_red_next   = pixel_red;
        a_max_next   = pixel_red;
        a_min        = pixel_red;
        if (pixel_green > a_max_next) a_max_next = pixel_green;
        if (pixel_blue  > a_max_next) a_max_next = pixel_blue;
        if (pixel_green < a_min) a_min = pixel_green;
        if (pixel_blue  < a_min) a_min = pixel_blue;
        a_diff_next = a_max_next - a_min;
        // ties go red first, then green
        priority if (a_max_next == pixel_red)   a_sec_next = SEC_RED;
        else if     (a_max_next == pixel_green) a_sec_next = SEC_GREEN;
        else                                    a_sec_next = SEC_BLUE;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            a_blue_reg  <= a_blue_next;
            a_green_reg <= a_green_next;
            a_red_reg   <= a_red_next;
            a_max_reg   <= a_max_next;
            a_diff_reg  <= a_diff_next;
            a_sec_reg   <= a_sec_next;
        end
    end

    // stage b: numerators and reciprocal lookups
    logic [NUM_W-1:0]   b_ns_reg, b_nh_reg, b_ns_next, b_nh_next;
    logic [RECIP_W-1:0] b_rs_reg, b_rh_reg, b_rs_next, b_rh_next;
    logic [7:0]         b_max_reg, b_diff_reg;
    logic [WIDE_W-1:0]  b_b60, b_g60, b_r60, b_d, b_hue_wide;

    always_comb
    begin
        b_b60 = WIDE_W'(a_blue_reg)  * WIDE_W'(60);
        b_g60 = WIDE_W'(a_green_reg) * WIDE_W'(60);
        b_r60 = WIDE_W'(a_red_reg)   * WIDE_W'(60);
        b_d   = WIDE_W'(a_diff_reg);
        // 60*num + 121*diff, always positive; modular arithmetic lands in range
        unique case (a_sec_reg)
            SEC_RED:   b_hue_wide = b_g60 - b_b60 + b_d * WIDE_W'(121);
            SEC_GREEN: b_hue_wide = b_b60 - b_r60 + b_d * WIDE_W'(241);
            SEC_BLUE:  b_hue_wide = b_r60 - b_g60 + b_d * WIDE_W'(361);
            default:   b_hue_wide = '0;
        endcase
        b_nh_next = b_hue_wide[NUM_W-1:0];
        b_ns_next = NUM_W'(a_diff_reg) * NUM_W'(510) + NUM_W'(a_max_reg);
        b_rs_next = recip_rom[a_max_reg];
        b_rh_next = recip_rom[a_diff_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b && vld_a_reg)
        begin
            b_ns_reg   <= b_ns_next;
            b_nh_reg   <= b_nh_next;
            b_rs_reg   <= b_rs_next;
            b_rh_reg   <= b_rh_next;
            b_max_reg  <= a_max_reg;
            b_diff_reg <= a_diff_reg;
        end
    end

    // stage c: quotient estimates
    logic [PROD_W-1:0] c_prod_s, c_prod_h;
    logic [7:0]        c_qs_reg, c_qh_reg, c_qs_next, c_qh_next;
    logic [NUM_W-1:0]  c_ns_reg, c_nh_reg;
    logic [7:0]        c_max_reg, c_diff_reg;

    always_comb
    begin
        c_prod_s  = PROD_W'(b_ns_reg) * PROD_W'(b_rs_reg);
        c_prod_h  = PROD_W'(b_nh_reg) * PROD_W'(b_rh_reg);
        c_qs_next = c_prod_s[RECIP_SHIFT +: 8];
        c_qh_next = c_prod_h[RECIP_SHIFT +: 8];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_c && vld_b_reg)
        begin
            c_qs_reg   <= c_qs_next;
            c_qh_reg   <= c_qh_next;
            c_ns_reg   <= b_ns_reg;
            c_nh_reg   <= b_nh_reg;
            c_max_reg  <= b_max_reg;
            c_diff_reg <= b_diff_reg;
        end
    end

    // stage d: one-step correction, hue offset, special cases
    logic [NUM_W-1:0] d_div_s, d_div_h, d_rem_s, d_rem_h;
    logic [7:0]       d_s, d_hq, d_h;
    hdcm_pkg::hsv_t   d_hsv_reg, d_hsv_next;

    always_comb
    begin
        d_div_s = NUM_W'({c_max_reg, 1'b0});
        d_div_h = NUM_W'({c_diff_reg, 1'b0});
        d_rem_s = c_ns_reg - NUM_W'(c_qs_reg) * d_div_s;
        d_rem_h = c_nh_reg - NUM_W'(c_qh_reg) * d_div_h;
        d_s  = c_qs_reg + 8'((d_rem_s >= d_div_s) ? 1 : 0);
        d_hq = c_qh_reg + 8'((d_rem_h >= d_div_h) ? 1 : 0);
        // half-degree hue, wrap negatives by 180
        d_h  = (d_hq < 8'd60) ? (d_hq + 8'd120) : (d_hq - 8'd60);
        d_hsv_next.v = c_max_reg;
        d_hsv_next.s = (c_max_reg == 8'd0)  ? 8'd0 : d_s;
        d_hsv_next.h = (c_diff_reg == 8'd0) ? 8'd0 : d_h;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_d && vld_c_reg)
        begin
            d_hsv_reg <= d_hsv_next;
        end
    end

    assign out_valid = vld_d_reg;
    assign out_hsv   = d_hsv_reg;

endmodule

/* rtl/hsv_dual_colour_mask.sv */
// top level: bgr pixel stream to yellow and blue hsv window masks
// One pixel per clock sustained while out_ready holds: every stage then takes a new
// transfer each cycle. A result passes through four conversion stages in
// hdcm_hsv_conv, then the window compare, which is also the output register.
// Saturation and hue divisions use a 256-entry reciprocal table, one multiply and
// a single correction step, so no iterative divider holds up the stream. A stall
// on the output backs up stage by stage; bubbles are squeezed out. The three
// bounds registers (index 0 yellow, 1 blue, 2 reflection; index 3 is ignored)
// pack h_min, h_max, s_min, s_max, v_min, v_max bytes from bit 0, and are meant
// to be written while no pixel is in flight.
module hsv_dual_colour_mask (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hdcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hdcm_pkg::BOUNDS_W-1:0]     cfg_data,
    // pixel input
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hdcm_pkg::CHAN_W-1:0]       pixel_blue,
    input  logic [hdcm_pkg::CHAN_W-1:0]       pixel_green,
    input  logic [hdcm_pkg::CHAN_W-1:0]       pixel_red,
    // mask output
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              yellow_hit,
    output logic                              blue_hit
);

    // window check on all three components, inclusive on both ends
    function automatic logic in_window(input logic [hdcm_pkg::BOUNDS_W-1:0] bounds,
                                       input hdcm_pkg::hsv_t px);
        in_window = (px.h >= bounds[7:0])   && (px.h <= bounds[15:8])  &&
                    (px.s >= bounds[23:16]) && (px.s <= bounds[31:24]) &&
                    (px.v >= bounds[39:32]) && (px.v <= bounds[47:40]);
    endfunction

    // bounds registers
    logic [hdcm_pkg::BOUNDS_W-1:0] yellow_bounds_reg, blue_bounds_reg, reflection_bounds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yellow_bounds_reg     <= hdcm_pkg::YELLOW_RESET;
            blue_bounds_reg       <= hdcm_pkg::BLUE_RESET;
            reflection_bounds_reg <= hdcm_pkg::REFLECTION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hdcm_pkg::CFG_YELLOW:     yellow_bounds_reg     <= cfg_data;
                hdcm_pkg::CFG_BLUE:       blue_bounds_reg       <= cfg_data;
                hdcm_pkg::CFG_REFLECTION: reflection_bounds_reg <= cfg_data;
                default:                  ; // unused index, write dropped
            endcase
        end
    end

    // hsv conversion pipeline
    logic           conv_valid;
    logic           conv_ready;
    hdcm_pkg::hsv_t conv_hsv;

    hdcm_hsv_conv u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_blue  (pixel_blue),
        .pixel_green (pixel_green),
        .pixel_red   (pixel_red),
        .out_valid   (conv_valid),
        .out_ready   (conv_ready),
        .out_hsv     (conv_hsv)
    );

    // compare stage doubles as the output register
    logic out_valid_reg;
    logic yellow_hit_reg, yellow_hit_next;
    logic blue_hit_reg, blue_hit_next;

    assign conv_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        yellow_hit_next = in_window(yellow_bounds_reg, conv_hsv);
        // reflections are carved out of the blue window
        blue_hit_next   = in_window(blue_bounds_reg, conv_hsv) &&
                          !in_window(reflection_bounds_reg, conv_hsv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (conv_ready)
        begin
            out_valid_reg <= conv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (conv_ready && conv_valid)
        begin
            yellow_hit_reg <= yellow_hit_next;
            blue_hit_reg   <= blue_hit_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign yellow_hit = yellow_hit_reg;
    assign blue_hit   = blue_hit_reg;

endmodule

/* verif/hsv_dual_colour_mask_tb.sv */
// self-checking testbench for the hsv dual colour mask: directed table plus random pixels
`timescale 1ns / 100ps

module hsv_dual_colour_mask_tb;

    // pixel to mask delay of the block, used for the quiet pause before window writes
    localparam int unsigned PIPE_LATENCY     = 5;
    // cycles with no transfer on any channel before the run is declared hung
    localparam int unsigned STALL_LIMIT      = 1000;
    localparam int unsigned RESET_RANDOM     = 90;
    localparam int unsigned RANDOM_PER_PHASE = 80;
    localparam int unsigned WINDOW_PHASES    = 7;
    localparam int unsigned PRINT_CAP        = 100;

    // index past the register list, the block drops writes to it
    localparam logic [hdcm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // window extremes: everything open, single point at zero, single point at 255
    localparam logic [hdcm_pkg::BOUNDS_W-1:0] BOUNDS_OPEN = 48'hFF00_FF00_FF00;
    localparam logic [hdcm_pkg::BOUNDS_W-1:0] BOUNDS_ZERO = '0;
    localparam logic [hdcm_pkg::BOUNDS_W-1:0] BOUNDS_ONES = '1;
    // yellow with hue limits swapped, reflection with saturation limits swapped
    localparam logic [hdcm_pkg::BOUNDS_W-1:0] YELLOW_FLIPPED =
        {hdcm_pkg::YELLOW_RESET[47:16], hdcm_pkg::YELLOW_RESET[7:0],
         hdcm_pkg::YELLOW_RESET[15:8]};
    localparam logic [hdcm_pkg::BOUNDS_W-1:0] REFLECTION_FLIPPED =
        {hdcm_pkg::REFLECTION_RESET[47:32], hdcm_pkg::REFLECTION_RESET[23:16],
         hdcm_pkg::REFLECTION_RESET[31:24], hdcm_pkg::REFLECTION_RESET[15:0]};

    typedef struct packed {
        logic yellow;
        logic blue;
    } mask_t;

    // one pixel with its mask; typed rows carry a hand-written mask
    typedef struct packed {
        logic [hdcm_pkg::CHAN_W-1:0] blue;
        logic [hdcm_pkg::CHAN_W-1:0] green;
        logic [hdcm_pkg::CHAN_W-1:0] red;
        logic                        typed;
        mask_t                       want;
    } pixel_row_t;

    localparam mask_t NO_HIT = '{yellow: 1'b0, blue: 1'b0};

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [hdcm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hdcm_pkg::BOUNDS_W-1:0]  cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [hdcm_pkg::CHAN_W-1:0]    pixel_blue;
    logic [hdcm_pkg::CHAN_W-1:0]    pixel_green;
    logic [hdcm_pkg::CHAN_W-1:0]    pixel_red;
    logic                           out_valid;
    logic                           out_ready;
    logic                           yellow_hit;
    logic                           blue_hit;

    // shadow copy of the three window registers
    logic [hdcm_pkg::BOUNDS_W-1:0] yellow_win;
    logic [hdcm_pkg::BOUNDS_W-1:0] blue_win;
    logic [hdcm_pkg::BOUNDS_W-1:0] reflect_win;

    // pixels taken by the block whose masks have not come back yet, oldest first
    pixel_row_t masks_due [$];

    int unsigned mismatches    = 0;
    int unsigned pixels_sent   = 0;
    int unsigned masks_checked = 0;
    int unsigned yellow_seen   = 0;
    int unsigned blue_seen     = 0;
    int unsigned settings_run  = 0;
    int unsigned quiet_cycles  = 0;
    // when set, neither side inserts idle cycles
    bit          steady_flow   = 1'b0;

    // directed pixels, blue/green/red order; masks typed in only where they are obvious
    pixel_row_t directed_rows [22] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, NO_HIT},  // black: h s v all zero
        '{8'd255, 8'd255, 8'd255, 1'b1, NO_HIT},  // white: grey at full scale
        '{8'd128, 8'd128, 8'd128, 1'b1, NO_HIT},  // mid grey
        '{8'd0,   8'd0,   8'd255, 1'b1, NO_HIT},  // pure red, hue zero
        '{8'd0,   8'd255, 8'd0,   1'b0, NO_HIT},  // pure green
        '{8'd255, 8'd0,   8'd0,   1'b0, NO_HIT},  // pure blue
        '{8'd0,   8'd255, 8'd255, 1'b0, NO_HIT},  // red and green share the max
        '{8'd255, 8'd255, 8'd0,   1'b0, NO_HIT},  // green and blue share the max
        '{8'd255, 8'd0,   8'd255, 1'b0, NO_HIT},  // red and blue share the max
        '{8'd1,   8'd0,   8'd0,   1'b0, NO_HIT},  // smallest nonzero value
        '{8'd0,   8'd1,   8'd0,   1'b0, NO_HIT},
        '{8'd0,   8'd0,   8'd1,   1'b0, NO_HIT},
        '{8'd100, 8'd0,   8'd255, 1'b0, NO_HIT},  // red max, hue wraps below zero
        '{8'd1,   8'd0,   8'd255, 1'b0, NO_HIT},  // wrap that rounds back to zero
        '{8'd0,   8'd128, 8'd255, 1'b0, NO_HIT},  // orange
        '{8'd40,  8'd200, 8'd220, 1'b0, NO_HIT},  // inside the yellow window
        '{8'd200, 8'd137, 8'd158, 1'b0, NO_HIT},  // blue but cut as a reflection
        '{8'd200, 8'd106, 8'd137, 1'b0, NO_HIT},  // blue that survives
        '{8'd254, 8'd1,   8'd127, 1'b0, NO_HIT},
        '{8'd0,   8'd60,  8'd255, 1'b0, NO_HIT},
        '{8'd64,  8'd255, 8'd254, 1'b0, NO_HIT},
        '{8'd255, 8'd254, 8'd1,   1'b0, NO_HIT}
    };

    hsv_dual_colour_mask DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_blue  (pixel_blue),
        .pixel_green (pixel_green),
        .pixel_red   (pixel_red),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .yellow_hit  (yellow_hit),
        .blue_hit    (blue_hit)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // bgr to 8-bit hsv: v is the max, s scaled to 255, h in half-degrees, all rounded half up
    function automatic hdcm_pkg::hsv_t pixel_to_hsv(input int b, input int g, input int r);
        int             mx;
        int             mn;
        int             diff;
        int             num;
        int             q;
        hdcm_pkg::hsv_t res;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        diff  = mx - mn;
        res.v = 8'(mx);
        res.s = (mx == 0) ? 8'd0 : 8'((510 * diff + mx) / (2 * mx));
        // grey and black have no hue
        if (diff == 0)
        begin
            res.h = 8'd0;
            return res;
        end
        // sector choice on ties: red first, then green
        if (mx == r)
            num = g - b;
        else if (mx == g)
            num = b - r + 2 * diff;
        else
            num = r - g + 4 * diff;
        // 30*num/diff rounded, biased upward so the division never sees a negative value
        q = (60 * num + 121 * diff) / (2 * diff) - 60;
        if (q < 0)
            q += 180;
        res.h = 8'(q);
        return res;
    endfunction

    // inclusive window test; min above max on any component never matches
    function automatic bit in_window(input logic [hdcm_pkg::BOUNDS_W-1:0] win,
                                     input hdcm_pkg::hsv_t c);
        return c.h >= win[7:0]   && c.h <= win[15:8]  &&
               c.s >= win[23:16] && c.s <= win[31:24] &&
               c.v >= win[39:32] && c.v <= win[47:40];
    endfunction

    function automatic mask_t predict_masks(input logic [hdcm_pkg::CHAN_W-1:0] b,
                                            input logic [hdcm_pkg::CHAN_W-1:0] g,
                                            input logic [hdcm_pkg::CHAN_W-1:0] r);
        hdcm_pkg::hsv_t c;
        mask_t          m;
        c        = pixel_to_hsv(b, g, r);
        m.yellow = in_window(yellow_win, c);
        m.blue   = in_window(blue_win, c) && !in_window(reflect_win, c);
        return m;
    endfunction

    // random window: each component ordered, now and then swapped, which empties it unless both limits are equal
    function automatic logic [hdcm_pkg::BOUNDS_W-1:0] draw_bounds();
        logic [hdcm_pkg::BOUNDS_W-1:0] win;
        int unsigned                   lo;
        int unsigned                   hi;
        for (int k = 0; k < 3; k++)
        begin
            lo = $urandom_range(0, 160);
            hi = $urandom_range(lo, 255);
            if ($urandom_range(0, 7) == 0)
                win[16*k +: 16] = {8'(lo), 8'(hi)};
            else
                win[16*k +: 16] = {8'(hi), 8'(lo)};
        end
        return win;
    endfunction

    // random pixel, steered toward the regions where the masks change
    task automatic draw_pixel(output logic [hdcm_pkg::CHAN_W-1:0] b,
                              output logic [hdcm_pkg::CHAN_W-1:0] g,
                              output logic [hdcm_pkg::CHAN_W-1:0] r);
        int unsigned top;
        int unsigned other;
        int unsigned spread;
        b = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        r = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:
            begin
                // near grey: channels a few steps apart
                top    = $urandom_range(0, 255);
                spread = $urandom_range(0, 3);
                b = 8'(top);
                g = 8'((top < spread) ? 0 : top - spread);
                r = 8'((top + spread > 255) ? 255 : top + spread);
            end
            1:
            begin
                // two channels tied at the max
                top   = $urandom_range(1, 255);
                other = $urandom_range(0, top - 1);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        r = 8'(top); g = 8'(top); b = 8'(other);
                    end
                    1:
                    begin
                        g = 8'(top); b = 8'(top); r = 8'(other);
                    end
                    default:
                    begin
                        r = 8'(top); b = 8'(top); g = 8'(other);
                    end
                endcase
            end
            2:
            begin
                // fully saturated: one channel at full scale, one at zero
                case ($urandom_range(0, 2))
                    0:
                    begin
                        r = 8'd255; b = 8'd0;
                    end
                    1:
                    begin
                        g = 8'd255; r = 8'd0;
                    end
                    default:
                    begin
                        b = 8'd255; g = 8'd0;
                    end
                endcase
            end
            3:
            begin
                // bluish, around the blue and reflection windows
                b = 8'($urandom_range(96, 255));
                g = 8'($urandom_range(0, b));
                r = 8'($urandom_range(0, b));
            end
            4:
            begin
                // yellowish: red and green high, blue low
                r = 8'($urandom_range(96, 255));
                g = 8'($urandom_range(r / 2, r));
                b = 8'($urandom_range(0, g / 2));
            end
            default:
            begin
                // uniform pixel, already drawn
            end
        endcase
    endtask

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] error: %s", $realtime, what);
    endtask

    // one pixel transfer; the mask it should produce is queued once the block takes it
    task automatic send_pixel(input pixel_row_t row);
        int unsigned gap;
        pixel_row_t  taken;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_blue  <= row.blue;
        pixel_green <= row.green;
        pixel_red   <= row.red;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        taken = row;
        if (!row.typed)
            taken.want = predict_masks(row.blue, row.green, row.red);
        masks_due.push_back(taken);
        pixels_sent++;
    endtask

    // hold the pixel side until every mask is back, then let the pipe settle
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (masks_due.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes never toggle it within one step
    task automatic write_reg(input logic [hdcm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hdcm_pkg::BOUNDS_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            hdcm_pkg::CFG_YELLOW:     yellow_win  = value;
            hdcm_pkg::CFG_BLUE:       blue_win    = value;
            hdcm_pkg::CFG_REFLECTION: reflect_win = value;
            default:
            begin
                // spare index, write is dropped
            end
        endcase
    endtask

    task automatic apply_setting(input logic [hdcm_pkg::BOUNDS_W-1:0] yellow,
                                 input logic [hdcm_pkg::BOUNDS_W-1:0] blue,
                                 input logic [hdcm_pkg::BOUNDS_W-1:0] reflect);
        wait_results_done();
        // junk to the spare index first, it must leave all windows alone
        write_reg(CFG_SPARE, {$urandom, $urandom});
        write_reg(hdcm_pkg::CFG_YELLOW, yellow);
        write_reg(hdcm_pkg::CFG_BLUE, blue);
        write_reg(hdcm_pkg::CFG_REFLECTION, reflect);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    task automatic run_random_pixels(input int unsigned count);
        pixel_row_t                  row;
        logic [hdcm_pkg::CHAN_W-1:0] b;
        logic [hdcm_pkg::CHAN_W-1:0] g;
        logic [hdcm_pkg::CHAN_W-1:0] r;
        for (int unsigned i = 0; i < count; i++)
        begin
            // switch between idling and full-rate stretches now and then
            if ($urandom_range(0, 31) == 0)
                steady_flow = !steady_flow;
            // midway the sender holds off until the pipe has fully drained
            if (i == count / 2)
                wait_results_done();
            draw_pixel(b, g, r);
            row = '{blue: b, green: g, red: r, typed: 1'b0, want: NO_HIT};
            send_pixel(row);
        end
    endtask

    // mask sink: random stall per transfer, ready held high across zero-stall transfers
    initial
    begin : mask_sink
        int unsigned stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // every mask transfer is matched against the oldest pixel still waiting
    always @(posedge clk)
    begin : mask_check
        pixel_row_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (masks_due.size() == 0)
                report($sformatf("mask y=%0b b=%0b with no pixel waiting", yellow_hit, blue_hit));
            else
            begin
                due = masks_due.pop_front();
                if (yellow_hit !== due.want.yellow)
                    report($sformatf("pixel b=%0d g=%0d r=%0d: yellow_hit %b, want %b",
                                     due.blue, due.green, due.red, yellow_hit, due.want.yellow));
                if (blue_hit !== due.want.blue)
                    report($sformatf("pixel b=%0d g=%0d r=%0d: blue_hit %b, want %b",
                                     due.blue, due.green, due.red, blue_hit, due.want.blue));
                masks_checked++;
                if (due.want.yellow) yellow_seen++;
                if (due.want.blue)   blue_seen++;
            end
        end
    end

    // watchdog: a hung handshake on any channel ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] error: no transfer for %0d cycles, %0d masks outstanding",
                     $realtime, STALL_LIMIT, masks_due.size());
            $display("hsv_dual_colour_mask: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= hdcm_pkg::CFG_YELLOW;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        pixel_blue  <= '0;
        pixel_green <= '0;
        pixel_red   <= '0;
        yellow_win  = hdcm_pkg::YELLOW_RESET;
        blue_win    = hdcm_pkg::BLUE_RESET;
        reflect_win = hdcm_pkg::REFLECTION_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table and a random batch under the reset windows
        foreach (directed_rows[i])
            send_pixel(directed_rows[i]);
        run_random_pixels(RESET_RANDOM);

        // window settings: extremes first, then random ones
        for (int p = 0; p < WINDOW_PHASES; p++)
        begin
            case (p)
                // yellow everything, blue everything but black
                0: apply_setting(BOUNDS_OPEN, BOUNDS_OPEN, BOUNDS_ZERO);
                // single-point windows, reflection swallows all blue
                1: apply_setting(BOUNDS_ONES, BOUNDS_ZERO, BOUNDS_OPEN);
                // empty yellow, reflection never matches
                2: apply_setting(YELLOW_FLIPPED, hdcm_pkg::BLUE_RESET, REFLECTION_FLIPPED);
                default: apply_setting(draw_bounds(), draw_bounds(), draw_bounds());
            endcase
            run_random_pixels(RANDOM_PER_PHASE);
        end

        wait_results_done();

        $display("run: %0d pixels over reset windows and %0d written settings, %0d masks checked",
                 pixels_sent, settings_run, masks_checked);
        $display("run: %0d yellow and %0d blue hits expected, %0d errors",
                 yellow_seen, blue_seen, mismatches);
        if (mismatches == 0)
            $display("hsv_dual_colour_mask: match");
        else
            $display("hsv_dual_colour_mask: mismatch");
        $finish;
    end

endmodule
